// ----- design/fdl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the fractional delay line.
package fdl_pkg;

	// Field and register widths
	localparam int unsigned WHOLE_W   = 17;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned GAIN_W    = 18;
	localparam int unsigned LEN_REG_W = 18;

	// Configuration port
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Register reset values
	localparam logic [GAIN_W-1:0]    GAIN_RESET   = 18'd65536;
	localparam logic [LEN_REG_W-1:0] LENGTH_RESET = LEN_REG_W'(44100 * 2);

	// Rounding half of a Q.16 product
	localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

	// Register index, taken from paddr word bits
	typedef enum logic [1:0] {
		REG_DELAY_WHOLE    = 2'd0,
		REG_DELAY_FRACTION = 2'd1,
		REG_OUT_GAIN       = 2'd2,
		REG_BUFFER_LENGTH  = 2'd3
	} reg_idx_t;

	// Request action codes
	typedef enum logic {
		ACT_PROCESS = 1'b0,
		ACT_TAP     = 1'b1
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_DIFF,
		ST_MUL1,
		ST_SUM,
		ST_MUL2,
		ST_RES
	} state_t;

	// Configuration register file contents
	typedef struct packed {
		logic [WHOLE_W-1:0]   delay_whole;
		logic [FRAC_W-1:0]    delay_fraction;
		logic [GAIN_W-1:0]    out_gain;
		logic [LEN_REG_W-1:0] buffer_length;
	} cfg_t;

endpackage

// ----- design/fractional_delay_line_unit.sv -----
`timescale 1ns / 1ps
// Top level: fractional delay line with linear interpolation and output gain.
//
//  Channel   Direction  Handshake           Payload
//  input     in         in_valid/in_ready   action, sample_in, tap_whole, tap_fraction
//  output    out        out_valid/out_ready sample_out
//  config    in/out     APB psel/penable    paddr, pwdata, prdata (4 registers)
//
// A request walks the states: the accepting cycle clamps the delay, the next
// forms both read addresses and issues the store reads (and the write of a process
// request), then difference, interpolation multiply, sum, gain multiply and
// round/saturate each have a state of their own; the result enters the output
// register when the last state finds the output register free.
// One request is in flight at a time; the next is taken as soon as the result
// has moved into the output register, even while that result is still waiting.
// After reset the store reads as zero at once: a fill count marks the written
// prefix, so no clearing pass is run.
// If the output register is still full when a result is ready, the sequencer
// holds in its last state until out_ready frees it.
module fractional_delay_line_unit
	import fdl_pkg::*;
#(
	parameter int unsigned DEPTH       = 131072,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [WHOLE_W-1:0]            tap_whole,
	input  logic [FRAC_W-1:0]             tap_fraction,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [PDATA_W-1:0]            pwdata,
	output logic [PDATA_W-1:0]            prdata,
	output logic                          pready
);

	localparam int unsigned SB     = SAMPLE_BITS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
	localparam int unsigned P1_W   = SB + FRAC_W + 2;
	localparam int unsigned P2_W   = SB + GAIN_W + 1;

	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
	localparam logic [CMP_W-1:0] LEN_MIN = CMP_W'(2);
	localparam logic [SB-1:0]    SAT_HI  = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0]    SAT_LO  = {1'b1, {(SB-1){1'b0}}};

	cfg_t cfg;

	state_t state_q, state_d;

	// Control outputs of the sequencer
	logic accept;
	logic mem_re;
	logic mem_we;
	logic load_res;

	// Effective length and delay clamp
	logic [CMP_W-1:0]  blen_c;
	logic [CMP_W-1:0]  len_c;
	logic [CMP_W-1:0]  len_m1;
	logic [CMP_W-1:0]  whole_c;
	logic [LEN_W-1:0]  len;
	logic [ADDR_W-1:0] whole_cl;
	logic [ADDR_W-1:0] wp_eff;

	// Persistent state
	logic [ADDR_W-1:0] wp_q;
	logic [LEN_W-1:0]  fill_q;

	// Request captured at acceptance
	logic                 act_s1;
	logic signed [SB-1:0] xn_s1;
	logic [ADDR_W-1:0]    whole_s1;
	logic [FRAC_W-1:0]    frac_s1;
	logic [ADDR_W-1:0]    wp_s1;

	// Address stage
	logic [LEN_W-1:0] wp_l;
	logic [LEN_W-1:0] wh_l;
	logic [LEN_W-1:0] r0_a;
	logic [LEN_W-1:0] r0_b;
	logic [LEN_W-1:0] r0;
	logic [LEN_W-1:0] r1;
	logic [LEN_W-1:0] wp_inc;
	logic             v0_s2;
	logic             v1_s2;

	// Store read data
	logic [SB-1:0] rd0;
	logic [SB-1:0] rd1;

	// Arithmetic stages
	logic signed [SB-1:0]   s0;
	logic signed [SB-1:0]   s1;
	logic signed [SB-1:0]   s0_s3;
	logic signed [SB:0]     diff_s3;
	logic signed [P1_W-1:0] prod_s4;
	logic signed [P1_W-1:0] rnd1;
	logic signed [P1_W-1:0] sh1;
	logic signed [P1_W-1:0] interp_w;
	logic signed [SB-1:0]   interp_s5;
	logic signed [P2_W-1:0] prod_s6;
	logic signed [P2_W-1:0] rnd2;
	logic signed [P2_W-1:0] y2;
	logic                   fits;
	logic [SB-1:0]          sat;
	logic [SB-1:0]          res;

	// Output register
	logic          out_valid_q;
	logic [SB-1:0] sample_out_q;

	fdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fdl_mem #(
		.DEPTH  (DEPTH),
		.WIDTH  (SB),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (wp_s1),
		.wdata  (xn_s1),
		.re     (mem_re),
		.raddr0 (r0[ADDR_W-1:0]),
		.raddr1 (r1[ADDR_W-1:0]),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// Clamp the programmed length to the store
	assign blen_c = CMP_W'(cfg.buffer_length);
	always_comb begin
		if (blen_c < LEN_MIN) begin
			len_c = LEN_MIN;
		end else if (blen_c > DEPTH_C) begin
			len_c = DEPTH_C;
		end else begin
			len_c = blen_c;
		end
	end
	assign len    = len_c[LEN_W-1:0];
	assign len_m1 = len_c - CMP_W'(1);

	// Pick and saturate the whole delay, and fold a stale write pointer
	assign whole_c  = (action == ACT_TAP) ? CMP_W'(tap_whole) : CMP_W'(cfg.delay_whole);
	assign whole_cl = (whole_c > len_m1) ? len_m1[ADDR_W-1:0] : whole_c[ADDR_W-1:0];
	assign wp_eff   = (LEN_W'(wp_q) < len) ? wp_q : '0;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		load_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				mem_re  = 1'b1;
				mem_we  = (act_s1 == ACT_PROCESS);
				state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_SUM;
			ST_SUM:  state_d = ST_MUL2;
			ST_MUL2: state_d = ST_RES;
			ST_RES: begin
				if (!out_valid_q || out_ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid & in_ready;

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= action;
			xn_s1    <= sample_in;
			whole_s1 <= whole_cl;
			frac_s1  <= (action == ACT_TAP) ? tap_fraction : cfg.delay_fraction;
			wp_s1    <= wp_eff;
		end
	end

	// Form both read addresses; r1 sits one entry further back
	assign wp_l   = LEN_W'(wp_s1);
	assign wh_l   = LEN_W'(whole_s1);
	assign r0_a   = wp_l - wh_l;
	assign r0_b   = wp_l + len - wh_l;
	assign r0     = (wp_l >= wh_l) ? r0_a : r0_b;
	assign r1     = (wp_l > wh_l) ? (r0_a - LEN_W'(1)) : (r0_b - LEN_W'(1));
	assign wp_inc = wp_l + LEN_W'(1);

	// Entries beyond the written prefix read as zero
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			v0_s2 <= (r0 < fill_q);
			v1_s2 <= (r1 < fill_q);
		end
	end

	// Advance the write pointer and grow the written prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (mem_we) begin
			wp_q <= (wp_inc >= len) ? '0 : wp_inc[ADDR_W-1:0];
			if (wp_l == fill_q) begin
				fill_q <= fill_q + LEN_W'(1);
			end
		end
	end

	// Substitute the input for s0 on a process request with zero whole delay
	always_comb begin
		if (act_s1 == ACT_PROCESS && whole_s1 == '0) begin
			s0 = xn_s1;
		end else begin
			s0 = v0_s2 ? $signed(rd0) : '0;
		end
		s1 = v1_s2 ? $signed(rd1) : '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			s0_s3   <= s0;
			diff_s3 <= {s1[SB-1], s1} - {s0[SB-1], s0};
		end
	end

	// Interpolation multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1) begin
			prod_s4 <= $signed({1'b0, frac_s1}) * diff_s3;
		end
	end

	// Round half up and add back to s0
	assign rnd1     = prod_s4 + $signed(P1_W'(ROUND_HALF));
	assign sh1      = rnd1 >>> FRAC_W;
	assign interp_w = P1_W'(s0_s3) + sh1;

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			interp_s5 <= interp_w[SB-1:0];
		end
	end

	// Gain multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL2) begin
			prod_s6 <= interp_s5 * $signed({1'b0, cfg.out_gain});
		end
	end

	// Round, saturate, and drop the gain for taps
	assign rnd2 = prod_s6 + $signed(P2_W'(ROUND_HALF));
	assign y2   = rnd2 >>> FRAC_W;
	assign fits = (y2[P2_W-1:SB-1] == '0) || (y2[P2_W-1:SB-1] == '1);
	assign sat  = fits ? y2[SB-1:0] : (y2[P2_W-1] ? SAT_LO : SAT_HI);
	assign res  = (act_s1 == ACT_TAP) ? interp_s5 : sat;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			sample_out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// The write pointer never runs ahead of the written prefix
	a_wp_in_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(wp_q) <= fill_q)
		else $error("write pointer beyond written prefix");

	// The written prefix only grows
	a_fill_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= $past(fill_q))
		else $error("fill count decreased");

	// The two taps of one request are distinct entries
	a_taps_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> (r0 != r1))
		else $error("interpolation taps coincide");

	// A result appears only out of the final state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RES))
		else $error("result loaded outside final state");

endmodule

// ----- design/fdl_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers for the fractional delay line.
module fdl_regs
	import fdl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_whole    <= '0;
			cfg_q.delay_fraction <= '0;
			cfg_q.out_gain       <= GAIN_RESET;
			cfg_q.buffer_length  <= LENGTH_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_DELAY_WHOLE:    cfg_q.delay_whole    <= pwdata[WHOLE_W-1:0];
				REG_DELAY_FRACTION: cfg_q.delay_fraction <= pwdata[FRAC_W-1:0];
				REG_OUT_GAIN:       cfg_q.out_gain       <= pwdata[GAIN_W-1:0];
				REG_BUFFER_LENGTH:  cfg_q.buffer_length  <= pwdata[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero-extended
	always_comb begin
		case (idx)
			REG_DELAY_WHOLE:    prdata = PDATA_W'(cfg_q.delay_whole);
			REG_DELAY_FRACTION: prdata = PDATA_W'(cfg_q.delay_fraction);
			REG_OUT_GAIN:       prdata = PDATA_W'(cfg_q.out_gain);
			REG_BUFFER_LENGTH:  prdata = PDATA_W'(cfg_q.buffer_length);
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- design/fdl_mem.sv -----
`timescale 1ns / 1ps
// Sample store: one write port, two registered read ports, read-first.
module fdl_mem #(
	parameter int unsigned DEPTH  = 131072,
	parameter int unsigned WIDTH  = 24,
	parameter int unsigned ADDR_W = 17
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr0,
	input  logic [ADDR_W-1:0] raddr1,
	output logic [WIDTH-1:0]  rdata0,
	output logic [WIDTH-1:0]  rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports return the old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ----- tb/tb_fractional_delay_line_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fractional delay line: random and directed requests, APB setup.
module tb_fractional_delay_line_unit;
	import fdl_pkg::*;

	localparam int unsigned DEPTH       = 131072;
	localparam int unsigned SAMPLE_BITS = 24;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned LONG_HOLD   = 400;

	typedef struct {
		action_t                        act;
		logic signed [SAMPLE_BITS-1:0]  smp;
		logic [WHOLE_W-1:0]             whole;
		logic [FRAC_W-1:0]              frac;
	} sample_req_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          action = ACT_PROCESS;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic [WHOLE_W-1:0]            tap_whole = '0;
	logic [FRAC_W-1:0]             tap_fraction = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [PADDR_W-1:0]            paddr = '0;
	logic [PDATA_W-1:0]            pwdata = '0;
	logic [PDATA_W-1:0]            prdata;
	logic                          pready;

	// Shadow registers and delay history
	logic [WHOLE_W-1:0]            cfg_whole = '0;
	logic [FRAC_W-1:0]             cfg_frac = '0;
	logic [GAIN_W-1:0]             cfg_gain = GAIN_RESET;
	logic [LEN_REG_W-1:0]          cfg_len = LENGTH_RESET;
	logic signed [SAMPLE_BITS-1:0] delay_mem [DEPTH];
	longint                        wr_pos = 0;

	sample_req_t                   sample_requests [$];
	logic signed [SAMPLE_BITS-1:0] due_samples [$];
	sample_req_t                   next_req;

	int unsigned                   tx_idle_pct = 7;
	int unsigned                   rx_idle_pct = 54;
	logic                          hold_wanted = 1'b0;
	logic                          hold_taken = 1'b0;
	int unsigned                   hold_left = 0;
	int unsigned                   mismatches = 0;
	int unsigned                   quiet_cycles = 0;

	fractional_delay_line_unit #(
		.DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.sample_in(sample_in),
		.tap_whole(tap_whole),
		.tap_fraction(tap_fraction),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out the delayed sample for one request and advance the history
	function automatic logic signed [SAMPLE_BITS-1:0] delayed_sample(input sample_req_t r);
		longint len, wp, whole, frac, r0, r1, s0, s1, x, y, lim;
		len = longint'(cfg_len);
		if (len < 2) len = 2;
		if (len > DEPTH) len = DEPTH;
		wp = (wr_pos < len) ? wr_pos : 0;
		x = longint'(r.smp);
		if (r.act == ACT_PROCESS) begin
			whole = longint'(cfg_whole);
			frac = longint'(cfg_frac);
		end else begin
			whole = longint'(r.whole);
			frac = longint'(r.frac);
		end
		if (whole > len - 1) whole = len - 1;
		r0 = (wp >= whole) ? wp - whole : wp + len - whole;
		r1 = (r0 == 0) ? len - 1 : r0 - 1;
		s0 = longint'(delay_mem[r0]);
		s1 = longint'(delay_mem[r1]);
		// current input replaces the newest tap on zero whole delay
		if (r.act == ACT_PROCESS && whole == 0) s0 = x;
		y = s0 + ((frac * (s1 - s0) + longint'(ROUND_HALF)) >>> FRAC_W);
		if (r.act == ACT_PROCESS) begin
			if (whole == 0 && frac == 0) y = x;
			y = (y * longint'(cfg_gain) + longint'(ROUND_HALF)) >>> FRAC_W;
			lim = longint'(1) <<< (SAMPLE_BITS - 1);
			if (y > lim - 1) y = lim - 1;
			if (y < -lim) y = -lim;
			delay_mem[wp] = r.smp;
			wp++;
			if (wp >= len) wp = 0;
			wr_pos = wp;
		end
		return y[SAMPLE_BITS-1:0];
	endfunction

	function automatic void queue_item(input action_t a, input logic [SAMPLE_BITS-1:0] s,
			input logic [WHOLE_W-1:0] w, input logic [FRAC_W-1:0] f);
		sample_req_t r;
		r.act = a;
		r.smp = s;
		r.whole = w;
		r.frac = f;
		sample_requests.push_back(r);
	endfunction

	// One APB write; the shadow copy follows at the access edge
	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DELAY_WHOLE:    cfg_whole = v[WHOLE_W-1:0];
			REG_DELAY_FRACTION: cfg_frac = v[FRAC_W-1:0];
			REG_OUT_GAIN:       cfg_gain = v[GAIN_W-1:0];
			default:            cfg_len = v[LEN_REG_W-1:0];
		endcase
	endtask

	task automatic program_regs(input logic [PDATA_W-1:0] whole, input logic [PDATA_W-1:0] frac,
			input logic [PDATA_W-1:0] gain, input logic [PDATA_W-1:0] len);
		apb_write(REG_DELAY_WHOLE, whole);
		apb_write(REG_DELAY_FRACTION, frac);
		apb_write(REG_OUT_GAIN, gain);
		apb_write(REG_BUFFER_LENGTH, len);
		@(negedge clk);
	endtask

	// Wait until every request is taken and answered, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		while (sample_requests.size() != 0 || in_valid || due_samples.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Request driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				next_req.act = action_t'(action);
				next_req.smp = sample_in;
				next_req.whole = tap_whole;
				next_req.frac = tap_fraction;
				due_samples.push_back(delayed_sample(next_req));
			end
			if (!(in_valid && !in_ready)) begin
				if (sample_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_req = sample_requests.pop_front();
					in_valid <= 1'b1;
					action <= next_req.act;
					sample_in <= next_req.smp;
					tap_whole <= next_req.whole;
					tap_fraction <= next_req.frac;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_wanted && !hold_taken) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_taken <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Result monitor: compare against the oldest expected sample
	always @(posedge clk or negedge arst_n) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: sample_out=%0d", sample_out);
			end else if (sample_out !== due_samples[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample_out mismatch: expected %0d, got %0d",
						due_samples[0], sample_out);
				void'(due_samples.pop_front());
			end else begin
				void'(due_samples.pop_front());
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned p;
		int unsigned eff;
		int unsigned k;
		action_t a;
		logic [SAMPLE_BITS-1:0] s;
		logic [WHOLE_W-1:0] w;

		for (k = 0; k < DEPTH; k++)
			delay_mem[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Pass-through at reset settings, then taps at assorted depths
		queue_item(ACT_PROCESS, 24'h7FFFFF, '0, '0);
		queue_item(ACT_PROCESS, 24'h800000, '0, '0);
		queue_item(ACT_PROCESS, 24'h000000, '0, '0);
		queue_item(ACT_PROCESS, 24'hFFFFFF, '0, '0);
		queue_item(ACT_PROCESS, 24'h555555, '0, '0);
		queue_item(ACT_PROCESS, 24'hAAAAAA, '0, '0);
		queue_item(ACT_TAP, '0, 17'd0, 16'd0);
		queue_item(ACT_TAP, '0, 17'd1, 16'd0);
		queue_item(ACT_TAP, '0, 17'd3, 16'hFFFF);
		queue_item(ACT_TAP, 24'hFFFFFF, 17'h1FFFF, 16'h8000);
		queue_item(ACT_TAP, '0, 17'd2, 16'h7FFF);
		settle();

		// Zero whole delay with a fraction, max gain, length shrunk below the write position
		program_regs(0, 32'h8000, 32'h3FFFF, 5);
		queue_item(ACT_PROCESS, 24'h7FFFFF, '0, '0);
		queue_item(ACT_PROCESS, 24'h800000, '0, '0);
		queue_item(ACT_PROCESS, 24'h000001, '0, '0);
		queue_item(ACT_PROCESS, 24'h000064, '0, '0);
		queue_item(ACT_TAP, '0, 17'd4, 16'd1);
		queue_item(ACT_TAP, '0, 17'd0, 16'hFFFF);

		for (p = 0; p < 9; p++) begin
			settle();
			case (p)
				0: program_regs(3, 32'h4000, 65536, 16);
				1: program_regs(32'h1FFFF, 32'hFFFF, 0, 2);
				2: program_regs(7, $urandom_range(65535), $urandom_range(262143), 40);
				3: program_regs(32'h1FFFF, 12345, 32'h3FFFF, 32'h3FFFF);
				4: program_regs(0, 32'h9000, 50000, 0);
				5: program_regs(1, 0, 65536, 1);
				6: program_regs($urandom_range(99), $urandom_range(65535),
					$urandom_range(262143), $urandom_range(2, 200));
				7: program_regs(20, 32'hFFFF, 131072, 131072);
				default: program_regs(0, 0, 65536, 64);
			endcase
			if (p < 3) begin
				tx_idle_pct = 7;
				rx_idle_pct = 54;
			end else if (p < 6) begin
				tx_idle_pct = 54;
				rx_idle_pct = 7;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (p == 1) hold_wanted = 1'b1;
			eff = 32'(cfg_len);
			if (eff < 2) eff = 2;
			if (eff > DEPTH - 1) eff = DEPTH - 1;
			repeat (95) begin
				a = ($urandom_range(3) == 0) ? ACT_TAP : ACT_PROCESS;
				case ($urandom_range(15))
					0: s = 24'h7FFFFF;
					1: s = 24'h800000;
					default: s = SAMPLE_BITS'($urandom);
				endcase
				if ($urandom_range(7) == 0) w = WHOLE_W'($urandom_range(131071));
				else w = WHOLE_W'($urandom_range(eff));
				queue_item(a, s, w, FRAC_W'($urandom_range(65535)));
			end
		end
		settle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- fractional_delay_line_unit.f -----
design/fdl_pkg.sv
design/fdl_regs.sv
design/fdl_mem.sv
design/fractional_delay_line_unit.sv
tb/tb_fractional_delay_line_unit.sv
